/* rtl/cc20_pkg.sv */
// ChaCha20 stream cipher: shared types, constants and round functions.
// No dependencies; imported by every other file of the block.
`default_nettype none

package cc20_pkg;

    localparam int DATA_W      = 64;
    localparam int WORD_W      = 32;
    localparam int CTR_W       = 32;
    localparam int POS_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_ROWS    = 4;
    localparam int STATE_WORDS = 16;
    localparam int KS_ROWS     = 8;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef logic [WORD_W-1:0]                    word_t;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0]   state_t;
    typedef logic [3:0][WORD_W-1:0]               quad_t;
    typedef logic [KS_ROWS-1:0][DATA_W-1:0]       ks_rows_t;

    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(KS_ROWS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_KEY3,
        REG_NONCE_LO,
        REG_NONCE_HI,
        REG_CTR_START
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_FINAL
    } bk_state_t;

    typedef struct packed {
        logic [KEY_ROWS-1:0][DATA_W-1:0] key;
        logic [DATA_W-1:0]               nonce_low;
        logic [WORD_W-1:0]               nonce_high;
    } cc20_cfg_t;

    typedef struct packed {
        logic              load;
        logic [CTR_W-1:0]  value;
    } ctr_load_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              eom;
        logic [POS_W-1:0]  pos;
        logic              new_block;
    } item_t;

    function automatic quad_t quarter(word_t a, word_t b, word_t c, word_t d);
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

    // One column round (diag = 0) or one diagonal round (diag = 1).
    function automatic state_t half_round(state_t w, logic diag);
        state_t r;
        r = w;
        if (!diag)
        begin
            {r[0], r[4], r[8],  r[12]} = quarter(w[0], w[4], w[8],  w[12]);
            {r[1], r[5], r[9],  r[13]} = quarter(w[1], w[5], w[9],  w[13]);
            {r[2], r[6], r[10], r[14]} = quarter(w[2], w[6], w[10], w[14]);
            {r[3], r[7], r[11], r[15]} = quarter(w[3], w[7], w[11], w[15]);
        end
        else
        begin
            {r[0], r[5], r[10], r[15]} = quarter(w[0], w[5], w[10], w[15]);
            {r[1], r[6], r[11], r[12]} = quarter(w[1], w[6], w[11], w[12]);
            {r[2], r[7], r[8],  r[13]} = quarter(w[2], w[7], w[8],  w[13]);
            {r[3], r[4], r[9],  r[14]} = quarter(w[3], w[4], w[9],  w[14]);
        end
        return r;
    endfunction

    function automatic state_t init_state(cc20_cfg_t c, word_t ctr);
        state_t s;
        s[0] = SIGMA0;
        s[1] = SIGMA1;
        s[2] = SIGMA2;
        s[3] = SIGMA3;
        for (int i = 0; i < KEY_ROWS; i++)
        begin
            s[4 + 2*i] = c.key[i][WORD_W-1:0];
            s[5 + 2*i] = c.key[i][DATA_W-1:WORD_W];
        end
        s[12] = ctr;
        s[13] = c.nonce_low[WORD_W-1:0];
        s[14] = c.nonce_low[DATA_W-1:WORD_W];
        s[15] = c.nonce_high;
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/cc20_if.sv */
// Channel interfaces of the ChaCha20 block: plaintext in, ciphertext out, config writes.
// Depends on cc20_pkg.
`default_nettype none

interface cc20_in_if import cc20_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_chunk;
    logic              end_of_message;

    modport source (output valid, output data_chunk, output end_of_message, input ready);
    modport sink   (input valid, input data_chunk, input end_of_message, output ready);
endinterface

interface cc20_out_if import cc20_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] cipher_chunk;
    logic              last_chunk;
    logic [CTR_W-1:0]  next_counter;

    modport source (output valid, output cipher_chunk, output last_chunk,
                    output next_counter, input ready);
    modport sink   (input valid, input cipher_chunk, input last_chunk,
                    input next_counter, output ready);
endinterface

interface cc20_cfg_if import cc20_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/chacha20_stream_cipher.sv */
// ChaCha20 (96-bit nonce) stream cipher, 64-bit chunks; chunks 1..7 of a block use the stored
// 64-byte keystream block, while chunk 0 waits for a new one, computed one half round per cycle
// through the shared round unit.
// A two-entry queue and an output register let input be taken while results wait.
// Reset (rst_n, async, active low): config, counter and chunk position to zero.
`default_nettype none

module chacha20_stream_cipher import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cc20_in_if.sink     plaintext,
    cc20_out_if.source  ciphertext,
    cc20_cfg_if.sink    cfg
);

    logic       q_push;
    item_t      q_item;
    logic       q_full;
    logic       q_pop;
    logic       head_valid;
    item_t      head_item;
    cc20_cfg_t  cfg_state;
    ctr_load_t  ctr_load;

    cc20_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .plaintext (plaintext),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item),
        .cfg_state (cfg_state),
        .ctr_load  (ctr_load)
    );

    cc20_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .cfg_state  (cfg_state),
        .ctr_load   (ctr_load),
        .ciphertext (ciphertext)
    );

endmodule

`default_nettype wire

/* rtl/cc20_front.sv */
// Front end: config register file, chunk position tracking and item tagging.
// Depends on cc20_pkg and cc20_if.
`default_nettype none

module cc20_front import cc20_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cc20_in_if.sink     plaintext,
    cc20_cfg_if.sink    cfg,
    input  wire logic   q_full,
    output logic        q_push,
    output item_t       q_item,
    output cc20_cfg_t   cfg_state,
    output ctr_load_t   ctr_load
);

    cc20_cfg_t         cfg_reg, cfg_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              in_acc;
    logic              cfg_acc;

    assign plaintext.ready = !q_full;
    assign cfg.ready       = 1'b1;
    assign in_acc          = plaintext.valid && !q_full;
    assign cfg_acc         = cfg.valid;

    assign q_push           = in_acc;
    assign q_item.data      = plaintext.data_chunk;
    assign q_item.eom       = plaintext.end_of_message;
    assign q_item.pos       = pos_reg;
    assign q_item.new_block = (pos_reg == '0);

    assign cfg_state = cfg_reg;

    always_comb
    begin
        cfg_next       = cfg_reg;
        pos_next       = pos_reg;
        ctr_load.load  = 1'b0;
        ctr_load.value = cfg.data[CTR_W-1:0];
        if (in_acc)
        begin
            if (plaintext.end_of_message || pos_reg == LAST_POS)
                pos_next = '0;
            else
                pos_next = pos_reg + POS_W'(1);
        end
        if (cfg_acc)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_KEY0:      cfg_next.key[0]     = cfg.data;
                REG_KEY1:      cfg_next.key[1]     = cfg.data;
                REG_KEY2:      cfg_next.key[2]     = cfg.data;
                REG_KEY3:      cfg_next.key[3]     = cfg.data;
                REG_NONCE_LO:  cfg_next.nonce_low  = cfg.data;
                REG_NONCE_HI:  cfg_next.nonce_high = cfg.data[WORD_W-1:0];
                REG_CTR_START:
                begin
                    ctr_load.load = 1'b1;
                    pos_next      = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cc20_fifo.sv */
// Two-entry queue of tagged items between the front end and the keystream core.
// Depends on cc20_pkg.
`default_nettype none

module cc20_fifo import cc20_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire item_t  push_item,
    input  wire logic   pop,
    output logic        full,
    output logic        head_valid,
    output item_t       head_item
);

    item_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

/* rtl/cc20_core.sv */
// Back end: shared half-round unit, keystream block store, block counter, output register.
// Depends on cc20_pkg and cc20_if.
`default_nettype none

module cc20_core import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire item_t      head_item,
    output logic            pop,
    input  wire cc20_cfg_t  cfg_state,
    input  wire ctr_load_t  ctr_load,
    cc20_out_if.source      ciphertext
);

    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W       = $clog2(HALF_ROUNDS);

    bk_state_t          state_reg, state_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic               fresh_reg, fresh_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    state_t             work_reg, work_next;
    ks_rows_t           ks_reg, ks_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic [CTR_W-1:0]   out_ctr_reg, out_ctr_next;
    state_t             init_words;
    state_t             final_words;
    logic               slot_free;

    assign ciphertext.valid        = out_valid_reg;
    assign ciphertext.cipher_chunk = out_data_reg;
    assign ciphertext.last_chunk   = out_last_reg;
    assign ciphertext.next_counter = out_ctr_reg;

    assign slot_free  = !out_valid_reg || ciphertext.ready;
    assign init_words = init_state(cfg_state, ctr_reg);

    always_comb
    begin
        for (int i = 0; i < STATE_WORDS; i++)
            final_words[i] = work_reg[i] + init_words[i];
    end

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        fresh_next     = fresh_reg;
        ctr_next       = ctr_reg;
        work_next      = work_reg;
        ks_next        = ks_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ctr_next   = out_ctr_reg;
        out_valid_next = out_valid_reg && !ciphertext.ready;
        pop            = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head_item.new_block && !fresh_reg)
                begin
                    work_next  = init_words;
                    rnd_next   = '0;
                    state_next = BK_ROUND;
                end
                else if (head_valid && slot_free)
                begin
                    pop            = 1'b1;
                    fresh_next     = 1'b0;
                    out_valid_next = 1'b1;
                    out_data_next  = head_item.data ^ ks_reg[head_item.pos];
                    out_last_next  = head_item.eom;
                    out_ctr_next   = ctr_reg;
                end
            end
            BK_ROUND:
            begin
                work_next = half_round(work_reg, rnd_reg[0]);
                if (rnd_reg == RND_W'(HALF_ROUNDS - 1))
                    state_next = BK_FINAL;
                else
                    rnd_next = rnd_reg + RND_W'(1);
            end
            BK_FINAL:
            begin
                ks_next    = ks_rows_t'(final_words);
                ctr_next   = ctr_reg + CTR_W'(1);
                fresh_next = 1'b1;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
        if (ctr_load.load)
        begin
            ctr_next   = ctr_load.value;
            fresh_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rnd_reg       <= '0;
            fresh_reg     <= 1'b0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            fresh_reg     <= fresh_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        ks_reg       <= ks_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ctr_reg  <= out_ctr_next;
    end

endmodule

`default_nettype wire

/* rtl/cc20_checker.sv */
// Port-level checker for chacha20_stream_cipher, attached by bind.
// Depends on cc20_pkg.
`default_nettype none

module cc20_checker import cc20_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [DATA_W-1:0]  out_data,
    input wire logic               out_last,
    input wire logic [CTR_W-1:0]   out_ctr
);

    logic [2:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
            pend_next = pend_reg + 3'd1;
        else if (out_acc && !in_acc)
            pend_next = pend_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({out_data, out_last, out_ctr}))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result without pending transaction");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'(FIFO_DEPTH + 1))
        else $error("more transactions in flight than storage holds");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (plaintext.valid),
    .in_ready  (plaintext.ready),
    .out_valid (ciphertext.valid),
    .out_ready (ciphertext.ready),
    .out_data  (ciphertext.cipher_chunk),
    .out_last  (ciphertext.last_chunk),
    .out_ctr   (ciphertext.next_counter)
);

`default_nettype wire

/* test/tb_chacha20_stream_cipher.sv */
// Self-checking testbench for chacha20_stream_cipher: encrypts 64-bit chunks and compares
// every ciphertext transaction against an in-bench ChaCha20 keystream predictor.
// Depends on cc20_pkg, the cc20_*_if interfaces and the RTL top level.
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher;
    import cc20_pkg::*;

    localparam int DR           = 10;
    localparam int DRAIN_CYCLES = 2 * DR + 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 84;
    localparam int HOLD_CYCLES  = 200;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              eom;
    } plain_item_t;

    typedef struct {
        logic [DATA_W-1:0] chunk;
        logic              last;
        logic [CTR_W-1:0]  ctr;
    } cipher_item_t;

    logic clk;
    logic rst_n;

    cc20_in_if  plain_ch ();
    cc20_out_if cipher_ch ();
    cc20_cfg_if cfg_ch ();

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (DR)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .plaintext  (plain_ch),
        .ciphertext (cipher_ch),
        .cfg        (cfg_ch)
    );

    plain_item_t  plain_q [$];
    cipher_item_t cipher_q [$];

    // predictor state
    logic [DATA_W-1:0] key_reg [KEY_ROWS];
    logic [DATA_W-1:0] nonce_lo_reg;
    word_t             nonce_hi_reg;
    word_t             blk_ctr;
    word_t             ks_words [STATE_WORDS];
    logic [POS_W-1:0]  chunk_pos;

    int           failures;
    int           cycles;
    int           gap_left;
    int           stall_left;
    int           hold_left;
    bit           quiet;
    plain_item_t  next_plain;
    cipher_item_t want;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void qround(inout word_t a, inout word_t b,
                                   inout word_t c, inout word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
    endfunction

    function automatic void next_keystream_block();
        word_t init_w [STATE_WORDS];
        word_t mix [STATE_WORDS];
        init_w[0] = SIGMA0;
        init_w[1] = SIGMA1;
        init_w[2] = SIGMA2;
        init_w[3] = SIGMA3;
        for (int i = 0; i < KEY_ROWS; i++)
        begin
            init_w[4 + 2*i] = key_reg[i][31:0];
            init_w[5 + 2*i] = key_reg[i][63:32];
        end
        init_w[12] = blk_ctr;
        init_w[13] = nonce_lo_reg[31:0];
        init_w[14] = nonce_lo_reg[63:32];
        init_w[15] = nonce_hi_reg;
        mix = init_w;
        for (int r = 0; r < DR; r++)
        begin
            qround(mix[0], mix[4], mix[8],  mix[12]);
            qround(mix[1], mix[5], mix[9],  mix[13]);
            qround(mix[2], mix[6], mix[10], mix[14]);
            qround(mix[3], mix[7], mix[11], mix[15]);
            qround(mix[0], mix[5], mix[10], mix[15]);
            qround(mix[1], mix[6], mix[11], mix[12]);
            qround(mix[2], mix[7], mix[8],  mix[13]);
            qround(mix[3], mix[4], mix[9],  mix[14]);
        end
        for (int i = 0; i < STATE_WORDS; i++)
            ks_words[i] = mix[i] + init_w[i];
        blk_ctr = blk_ctr + 1;
    endfunction

    function automatic void encrypt_chunk(logic [DATA_W-1:0] data, logic eom);
        cipher_item_t c;
        if (chunk_pos == 0)
            next_keystream_block();
        c.chunk = data ^ {ks_words[2*chunk_pos + 1], ks_words[2*chunk_pos]};
        c.last  = eom;
        c.ctr   = blk_ctr;
        cipher_q.push_back(c);
        chunk_pos = (eom || chunk_pos == LAST_POS) ? '0 : chunk_pos + 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_KEY0:     key_reg[0] = val;
            REG_KEY1:     key_reg[1] = val;
            REG_KEY2:     key_reg[2] = val;
            REG_KEY3:     key_reg[3] = val;
            REG_NONCE_LO: nonce_lo_reg = val;
            REG_NONCE_HI: nonce_hi_reg = val[31:0];
            REG_CTR_START:
            begin
                blk_ctr   = val[31:0];
                chunk_pos = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [31:0] pick_ctr();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'hffff_ffff - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic push_chunk(logic [DATA_W-1:0] data, logic eom);
        plain_item_t p;
        p.data = data;
        p.eom  = eom;
        plain_q.push_back(p);
    endtask

    task automatic push_message(int len, bit with_eom);
        for (int i = 0; i < len; i++)
            push_chunk(rand64(), with_eom && (i == len - 1));
    endtask

    // sampled mid-cycle so the driver's and monitor's updates of this edge have settled
    task automatic wait_drained();
        @(negedge clk);
        while (plain_q.size() != 0 || cipher_q.size() != 0 || plain_ch.valid)
            @(negedge clk);
    endtask

    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        plain_ch.valid          = 1'b0;
        plain_ch.data_chunk     = '0;
        plain_ch.end_of_message = 1'b0;
        cipher_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // plaintext driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            plain_ch.valid <= 1'b0;
            gap_left       <= 0;
        end
        else
        begin
            if (plain_ch.valid && plain_ch.ready)
                encrypt_chunk(plain_ch.data_chunk, plain_ch.end_of_message);
            if (!plain_ch.valid || plain_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    plain_ch.valid <= 1'b0;
                    gap_left       <= gap_left - 1;
                end
                else if (plain_q.size() == 0)
                    plain_ch.valid <= 1'b0;
                else if (!quiet && $urandom_range(0, 4) == 0)
                begin
                    plain_ch.valid <= 1'b0;
                    gap_left       <= $urandom_range(0, 3);
                end
                else
                begin
                    next_plain              = plain_q.pop_front();
                    plain_ch.valid          <= 1'b1;
                    plain_ch.data_chunk     <= next_plain.data;
                    plain_ch.end_of_message <= next_plain.eom;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ciphertext ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cipher_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (hold_left > 0)
            cipher_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            cipher_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            cipher_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 3);
        end
        else
            cipher_ch.ready <= 1'b1;
    end

    // ciphertext monitor
    always @(posedge clk)
    begin
        if (rst_n && cipher_ch.valid && cipher_ch.ready)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got chunk %h",
                         $time, cipher_ch.cipher_chunk);
                failures++;
            end
            else
            begin
                want = cipher_q.pop_front();
                if (cipher_ch.cipher_chunk !== want.chunk)
                begin
                    $display("%0t: cipher_chunk expected %h, got %h",
                             $time, want.chunk, cipher_ch.cipher_chunk);
                    failures++;
                end
                if (cipher_ch.last_chunk !== want.last)
                begin
                    $display("%0t: last_chunk expected %b, got %b",
                             $time, want.last, cipher_ch.last_chunk);
                    failures++;
                end
                if (cipher_ch.next_counter !== want.ctr)
                begin
                    $display("%0t: next_counter expected %h, got %h",
                             $time, want.ctr, cipher_ch.next_counter);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int n;
        int len;
        failures  = 0;
        cycles    = 0;
        hold_left = 0;
        quiet     = 1'b0;
        for (int i = 0; i < KEY_ROWS; i++)
            key_reg[i] = '0;
        nonce_lo_reg = '0;
        nonce_hi_reg = '0;
        blk_ctr      = '0;
        chunk_pos    = '0;
        for (int i = 0; i < STATE_WORDS; i++)
            ks_words[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: one full block with extreme data, then a one-chunk message
        push_chunk('0, 1'b0);
        push_chunk('1, 1'b0);
        push_chunk(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        push_chunk(64'h5555_5555_5555_5555, 1'b0);
        for (int i = 0; i < 4; i++)
            push_chunk(rand64(), 1'b0);
        push_chunk(rand64(), 1'b1);
        wait_drained();

        // all-ones key and nonce, counter wraps past its top
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY2, '1);
        write_reg(REG_KEY3, '1);
        write_reg(REG_NONCE_LO, '1);
        write_reg(REG_NONCE_HI, 64'hffff_ffff);
        write_reg(REG_CTR_START, 64'hffff_ffff);
        write_reg(REG_NONE, rand64());
        push_chunk('1, 1'b0);
        push_chunk('0, 1'b1);
        push_message(3, 1'b0);
        wait_drained();

        // key/nonce change mid-block: current keystream stays until the block ends
        write_reg(REG_KEY0, 64'h0706_0504_0302_0100);
        write_reg(REG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
        write_reg(REG_KEY2, 64'h1716_1514_1312_1110);
        write_reg(REG_KEY3, 64'h1f1e_1d1c_1b1a_1918);
        write_reg(REG_NONCE_LO, 64'h4a00_0000_0900_0000);
        write_reg(REG_NONCE_HI, '0);
        push_message(7, 1'b0);
        wait_drained();

        // counter reload mid-block restarts at chunk 0
        write_reg(REG_CTR_START, 64'd1);
        push_message(2, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == RAND_PHASES - 1)
                quiet = 1'b1;
            if ($urandom_range(0, 1)) write_reg(REG_KEY0, pick64());
            if ($urandom_range(0, 1)) write_reg(REG_KEY1, pick64());
            if ($urandom_range(0, 1)) write_reg(REG_KEY2, pick64());
            if ($urandom_range(0, 1)) write_reg(REG_KEY3, pick64());
            if ($urandom_range(0, 1)) write_reg(REG_NONCE_LO, pick64());
            if ($urandom_range(0, 1)) write_reg(REG_NONCE_HI, {32'h0, pick_ctr()});
            if ($urandom_range(0, 2) != 0) write_reg(REG_CTR_START, {32'h0, pick_ctr()});
            if ($urandom_range(0, 7) == 0) write_reg(REG_NONE, rand64());
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                push_message(len, $urandom_range(0, 7) != 0);
                n += len;
            end
            if (ph == 1)
            begin
                @(posedge clk);
                hold_left <= HOLD_CYCLES;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cc20_pkg.sv
rtl/cc20_if.sv
rtl/cc20_front.sv
rtl/cc20_fifo.sv
rtl/cc20_core.sv
rtl/chacha20_stream_cipher.sv
rtl/cc20_checker.sv
test/tb_chacha20_stream_cipher.sv
